// ===== sv/integer_iq_upconverter_core_macros.svh =====
// assertion macros for the iq up-converter
`ifndef INTEGER_IQ_UPCONVERTER_CORE_MACROS_SVH
`define INTEGER_IQ_UPCONVERTER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IQUP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iqup implication check failed");

// antecedent implies consequent in the next cycle
`define IQUP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iqup next-cycle check failed");

`endif

// ===== sv/iqup_pkg.sv =====
// shared types, constants and table functions for the iq up-converter
package iqup_pkg;

  localparam int LUT_ADDR_BITS_DEF     = 12;
  localparam int WEIGHT_INDEX_BITS_DEF = 10;

  localparam logic [22:0] RATIO_RESET  = 23'd3276800;
  localparam logic [22:0] RATIO_MAX    = 23'd4194304;
  localparam logic [15:0] GAIN_RESET   = 16'd32767;
  localparam logic [22:0] PHASE_ONE    = 23'd65536;
  localparam logic [5:0]  RUN_LAST_CNT = 6'd63;

  localparam real PI_R = 3.14159265358979323846;

  typedef enum logic [2:0] {
    CFG_RATIO  = 3'd0,
    CFG_STEP   = 3'd1,
    CFG_GAIN   = 3'd2,
    CFG_FORMAT = 3'd3,
    CFG_OFFSET = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FMT_BYTE   = 2'd0,
    FMT_WORD   = 2'd1,
    FMT_WORD8  = 2'd2,
    FMT_SPARE  = 2'd3
  } fmt_t;

  typedef enum logic [3:0] {
    ST_FILL, ST_IDLE, ST_DIV, ST_RD, ST_BLA, ST_BLB, ST_FIR, ST_MIX, ST_GAIN, ST_FMT
  } state_t;

  // round(32767*sin(pi/2*k/2^qb))
  function automatic int sin_q15(input int k, input int qb);
    real x;
    begin
      x = PI_R * real'(k) * (0.5 ** (qb + 1));
      return $rtoi(32767.0 * $sin(x) + 0.5);
    end
  endfunction

  // round(16384*(1-cos(pi*k/2^wb)))
  function automatic int weight_q15(input int k, input int wb);
    real x;
    begin
      x = PI_R * real'(k) * (0.5 ** wb);
      return $rtoi(16384.0 * (1.0 - $cos(x)) + 0.5);
    end
  endfunction

endpackage

// ===== sv/iqup_ram.sv =====
// generic ram, one write port, two registered read ports
module iqup_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         ra_data,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// ===== sv/integer_iq_upconverter_core.sv =====
// iq up-converter top level: interpolation, fir, nco mixer, gain and format
//
// channel  dir  handshake          payload
// in       in   in_tvalid/tready   in_tdata = {in_q, in_i}
// out      out  out_tvalid/tready  out_tdata = rf_sample, out_tlast = last_of_run
// cfg      in   cfg_wr_en          cfg_index, cfg_data
//
// one request yields up to 64 rf samples; each sample steps through the bit-serial
// divider for the weight index, then rom read, blend, fir, mixer, gain and format.
// a request that yields no sample is accepted in idle without leaving it.
// after reset the sine and weight roms are filled before in_tready rises.
// a stalled output holds the sequencer until the result register frees up.
`include "integer_iq_upconverter_core_macros.svh"
module integer_iq_upconverter_core
  import iqup_pkg::*;
#(
  parameter int LUT_ADDR_BITS     = LUT_ADDR_BITS_DEF,
  parameter int WEIGHT_INDEX_BITS = WEIGHT_INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // in_i[15:0], in_q[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // rf_sample[15:0]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int QD      = 1 << (LUT_ADDR_BITS - 2);
  localparam int QDEPTH  = QD + 1;
  localparam int QAW     = LUT_ADDR_BITS - 1;
  localparam int WB      = WEIGHT_INDEX_BITS;
  localparam int WDEPTH  = 1 << WB;
  localparam int FILL_LEN = (QDEPTH > WDEPTH) ? QDEPTH : WDEPTH;
  localparam int FAW     = $clog2(FILL_LEN);
  localparam int DCW     = $clog2(WB);

  typedef logic [14:0] sin_tab_t [QDEPTH];
  typedef logic [15:0] wt_tab_t [WDEPTH];

  function automatic sin_tab_t build_sin();
    sin_tab_t t;
    begin
      for (int k = 0; k < QDEPTH; k++) t[k] = 15'(sin_q15(k, LUT_ADDR_BITS - 2));
      return t;
    end
  endfunction

  function automatic wt_tab_t build_wt();
    wt_tab_t t;
    begin
      for (int k = 0; k < WDEPTH; k++) t[k] = 16'(weight_q15(k, WB));
      return t;
    end
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin();
  localparam wt_tab_t  WT_TAB  = build_wt();

  // configuration
  logic [22:0] ratio_cfg_r;
  logic [31:0] step_r;
  logic [15:0] gain_r;
  logic [1:0]  fmt_r;
  logic        offs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_cfg_r <= RATIO_RESET;
      step_r      <= '0;
      gain_r      <= GAIN_RESET;
      fmt_r       <= FMT_WORD;
      offs_r      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RATIO:  ratio_cfg_r <= cfg_data[22:0];
        CFG_STEP:   step_r      <= cfg_data;
        CFG_GAIN:   gain_r      <= cfg_data[15:0];
        CFG_FORMAT: fmt_r       <= cfg_data[1:0];
        CFG_OFFSET: offs_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  state_t st_r, st_nxt;

  logic [FAW-1:0]   fill_r;
  logic [22:0]      phase_r, ratio_r;
  logic [31:0]      nco_r;
  logic [22:0]      rem_r;
  logic [WB-1:0]    m_r;
  logic [DCW-1:0]   dcnt_r;
  logic [5:0]       cnt_r;
  logic signed [15:0] prev_i_r, prev_q_r, ni_r, nq_r;
  logic signed [15:0] line_i_r [6];
  logic signed [15:0] line_q_r [6];
  logic [15:0]      w_r;
  logic signed [32:0] pa_i_r, pa_q_r;
  logic signed [15:0] ci_r, cq_r, fi_r, fq_r;
  logic signed [17:0] mix_r;
  logic signed [19:0] val_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_last_r;

  logic [22:0] ratio_c;
  logic        accept, fill_done, div_done, out_free, run_more;
  logic [22:0] phase_inc;
  logic [23:0] rem_dbl;
  logic        rem_ge;

  assign ratio_c   = (ratio_cfg_r > RATIO_MAX) ? RATIO_MAX : ratio_cfg_r;
  assign accept    = in_tvalid && in_tready;
  assign fill_done = (fill_r == FAW'(FILL_LEN - 1));
  assign div_done  = (dcnt_r == DCW'(WB - 1));
  assign out_free  = !out_valid_r || out_tready;
  assign phase_inc = phase_r + PHASE_ONE;
  assign run_more  = (phase_inc < ratio_r) && (cnt_r != RUN_LAST_CNT);
  assign rem_dbl   = {rem_r, 1'b0};
  assign rem_ge    = (rem_dbl >= {1'b0, ratio_r});

  // roms
  logic [LUT_ADDR_BITS-1:0] lut_idx;
  logic [1:0]     quad;
  logic [QAW-1:0] r_ext, r_mir, sine_rd_addr, cos_addr;
  logic [14:0]    sin_mag, cos_mag;
  logic [15:0]    wt_data, wt_unused;
  logic           sin_we, wt_we;

  assign lut_idx  = nco_r[31 -: LUT_ADDR_BITS];
  assign quad     = lut_idx[LUT_ADDR_BITS-1 -: 2];
  assign r_ext    = {1'b0, lut_idx[LUT_ADDR_BITS-3:0]};
  assign r_mir    = QAW'(QD) - r_ext;
  assign sine_rd_addr = quad[0] ? r_mir : r_ext;
  assign cos_addr = quad[0] ? r_ext : r_mir;
  assign sin_we   = (st_r == ST_FILL) && (fill_r < FAW'(QDEPTH));
  assign wt_we    = (st_r == ST_FILL) && ({1'b0, fill_r} < (FAW + 1)'(WDEPTH));

  iqup_ram #(.WIDTH(15), .DEPTH(QDEPTH)) u_sin_rom (
    .clk     (clk),
    .we      (sin_we),
    .waddr   (fill_r[QAW-1:0]),
    .wdata   (SIN_TAB[fill_r[QAW-1:0]]),
    .ra_addr (sine_rd_addr),
    .rb_addr (cos_addr),
    .ra_data (sin_mag),
    .rb_data (cos_mag)
  );

  iqup_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wt_rom (
    .clk     (clk),
    .we      (wt_we),
    .waddr   (fill_r[WB-1:0]),
    .wdata   (WT_TAB[fill_r[WB-1:0]]),
    .ra_addr (m_r),
    .rb_addr (m_r),
    .ra_data (wt_data),
    .rb_data (wt_unused)
  );

  // datapath values
  logic signed [16:0] w_s, inv_w_s, gain_s;
  logic signed [33:0] bsum_i, bsum_q;
  logic signed [22:0] facc_i, facc_q;
  logic signed [15:0] sin_v, cos_v;
  logic signed [32:0] mix_diff;
  logic signed [34:0] gprod;
  logic signed [19:0] clip_v, lim;
  logic [15:0]        word;
  logic [19:0]        byte_v;

  assign w_s     = $signed({1'b0, w_r});
  assign inv_w_s = $signed(17'd32768 - {1'b0, wt_data});
  assign gain_s  = $signed({1'b0, gain_r});
  assign bsum_i  = 34'(pa_i_r) + 34'(ni_r * w_s);
  assign bsum_q  = 34'(pa_q_r) + 34'(nq_r * w_s);
  assign facc_i  = 23'(4 * line_i_r[0] + 16 * line_i_r[1] + 26 * line_i_r[2]
                   + 36 * line_i_r[3] + 26 * line_i_r[4] + 16 * line_i_r[5] + 4 * ci_r);
  assign facc_q  = 23'(4 * line_q_r[0] + 16 * line_q_r[1] + 26 * line_q_r[2]
                   + 36 * line_q_r[3] + 26 * line_q_r[4] + 16 * line_q_r[5] + 4 * cq_r);
  assign sin_v   = quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign cos_v   = (quad == 2'd1 || quad == 2'd2) ? -$signed({1'b0, cos_mag})
                                                  : $signed({1'b0, cos_mag});
  assign mix_diff = 33'(fi_r * cos_v) - 33'(fq_r * sin_v);
  assign gprod    = 35'(mix_r * gain_s);
  assign lim      = (fmt_r == FMT_BYTE || fmt_r == FMT_WORD8) ? 20'sd127 : 20'sd32767;
  assign clip_v   = (val_r > lim) ? lim : ((val_r < -lim) ? -lim : val_r);
  assign byte_v   = offs_r ? 20'(clip_v + 20'sd128) : clip_v;
  assign word     = (fmt_r == FMT_BYTE) ? {8'd0, byte_v[7:0]} : clip_v[15:0];

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_FILL: if (fill_done) st_nxt = ST_IDLE;
      ST_IDLE: if (accept && (phase_r < ratio_c)) st_nxt = ST_DIV;
      ST_DIV:  if (div_done) st_nxt = ST_RD;
      ST_RD:   st_nxt = ST_BLA;
      ST_BLA:  st_nxt = ST_BLB;
      ST_BLB:  st_nxt = ST_FIR;
      ST_FIR:  st_nxt = ST_MIX;
      ST_MIX:  st_nxt = ST_GAIN;
      ST_GAIN: st_nxt = ST_FMT;
      ST_FMT:  if (out_free) st_nxt = run_more ? ST_DIV : ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (st_r == ST_IDLE);
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
    out_tlast  = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_FILL;
      fill_r      <= '0;
      phase_r     <= '0;
      nco_r       <= '0;
      prev_i_r    <= '0;
      prev_q_r    <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        line_i_r[k] <= '0;
        line_q_r[k] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_FMT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_FILL: fill_r <= fill_r + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            ni_r    <= $signed(in_tdata[15:0]);
            nq_r    <= $signed(in_tdata[31:16]);
            ratio_r <= ratio_c;
            cnt_r   <= '0;
            if (phase_r < ratio_c) begin
              rem_r  <= phase_r;
              dcnt_r <= '0;
              nco_r  <= nco_r + step_r;
            end else begin
              phase_r  <= phase_r - ratio_c;
              prev_i_r <= $signed(in_tdata[15:0]);
              prev_q_r <= $signed(in_tdata[31:16]);
            end
          end
        end
        ST_DIV: begin
          rem_r  <= rem_ge ? 23'(rem_dbl - {1'b0, ratio_r}) : rem_dbl[22:0];
          m_r    <= {m_r[WB-2:0], rem_ge};
          dcnt_r <= dcnt_r + 1'b1;
        end
        ST_BLA: begin
          w_r    <= wt_data;
          pa_i_r <= prev_i_r * inv_w_s;
          pa_q_r <= prev_q_r * inv_w_s;
        end
        ST_BLB: begin
          ci_r <= bsum_i[30:15];
          cq_r <= bsum_q[30:15];
        end
        ST_FIR: begin
          fi_r <= facc_i[22:7];
          fq_r <= facc_q[22:7];
          for (int k = 0; k < 5; k++) begin
            line_i_r[k] <= line_i_r[k+1];
            line_q_r[k] <= line_q_r[k+1];
          end
          line_i_r[5] <= ci_r;
          line_q_r[5] <= cq_r;
        end
        ST_MIX:  mix_r <= mix_diff[32:15];
        ST_GAIN: val_r <= gprod[34:15];
        ST_FMT: begin
          if (out_free) begin
            out_data_r  <= word;
            out_last_r  <= !run_more;
            cnt_r       <= cnt_r + 1'b1;
            if (run_more) begin
              phase_r <= phase_inc;
              rem_r   <= phase_inc;
              dcnt_r  <= '0;
              nco_r   <= nco_r + step_r;
            end else begin
              phase_r  <= phase_inc - ratio_r;
              prev_i_r <= ni_r;
              prev_q_r <= nq_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `IQUP_ASSERT_IMPL(a_div_in_run, st_r == ST_DIV, phase_r < ratio_r)
  `IQUP_ASSERT_IMPL(a_ready_only_idle, in_tready, st_r == ST_IDLE)
  `IQUP_ASSERT_NEXT(a_load_sets_valid, st_r == ST_FMT && out_free, out_tvalid)
  `IQUP_ASSERT_IMPL(a_valid_from_fmt, $rose(out_tvalid), $past(st_r == ST_FMT))

endmodule

// ===== tb/sv/integer_iq_upconverter_core_test.sv =====
// self-checking testbench for the iq up-converter core with random stimulus and stalls
`timescale 1ns / 1ps
module integer_iq_upconverter_core_test;
  import iqup_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
  localparam logic [63:0] Q62_HALF_PI = 64'h6487_ED51_10B4_611A;

  typedef struct {
    logic [15:0] rf;
    logic        last;
  } rf_exp_t;

  class upconv_scoreboard;
    int cos_tab[4096];
    int sin_tab[4096];
    int wt_tab[1024];
    logic [22:0] ratio_q16;
    logic [31:0] phase_step;
    logic [15:0] gain;
    fmt_t        fmt;
    logic        offset_bin;
    logic [22:0] interp_phase;
    logic [31:0] nco_phase;
    longint      prev_i, prev_q;
    longint      line_i[6], line_q[6];
    rf_exp_t     rf_q[$];
    int          errors;

    function new();
      logic [63:0] step, wstep, x, v;
      int s, c;
      step = Q62_HALF_PI >> 10;
      wstep = Q62_HALF_PI >> 9;
      for (int k = 0; k < 4096; k++) begin
        x = step * 64'(k & 1023);
        s = to_q15(sin_q62(x));
        c = to_q15(cos_q62(x));
        case ((k >> 10) & 3)
          0: begin sin_tab[k] = s;  cos_tab[k] = c;  end
          1: begin sin_tab[k] = c;  cos_tab[k] = -s; end
          2: begin sin_tab[k] = -s; cos_tab[k] = -c; end
          default: begin sin_tab[k] = -c; cos_tab[k] = s; end
        endcase
      end
      for (int k = 0; k < 1024; k++) begin
        if (k < 512) v = Q62_ONE - cos_q62(wstep * 64'(k));
        else v = Q62_ONE + sin_q62(wstep * 64'(k - 512));
        wt_tab[k] = int'((v + (64'd1 << 47)) >> 48);
      end
      ratio_q16 = RATIO_RESET;
      phase_step = '0;
      gain = GAIN_RESET;
      fmt = FMT_WORD;
      offset_bin = 1'b0;
      interp_phase = '0;
      nco_phase = '0;
      prev_i = 0;
      prev_q = 0;
      foreach (line_i[k]) begin
        line_i[k] = 0;
        line_q[k] = 0;
      end
      errors = 0;
    endfunction

    function logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
    endfunction

    function logic [63:0] sin_q62(logic [63:0] x);
      logic [63:0] x2, t, s;
      x2 = mul_q62(x, x);
      t = x;
      s = x;
      for (int k = 1; k < 40 && t != 0; k++) begin
        t = mul_q62(t, x2) / 64'((2 * k) * (2 * k + 1));
        if (k & 1) s = s - t;
        else s = s + t;
      end
      return s;
    endfunction

    function logic [63:0] cos_q62(logic [63:0] x);
      logic [63:0] x2, t, s;
      x2 = mul_q62(x, x);
      t = Q62_ONE;
      s = Q62_ONE;
      for (int k = 1; k < 40 && t != 0; k++) begin
        t = mul_q62(t, x2) / 64'((2 * k - 1) * (2 * k));
        if (k & 1) s = s - t;
        else s = s + t;
      end
      return s;
    endfunction

    function int to_q15(logic [63:0] v);
      logic [63:0] p;
      p = 64'd32767 * (v >> 16);
      return int'((p + (64'd1 << 45)) >> 46);
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_RATIO:  ratio_q16 = val[22:0];
        CFG_STEP:   phase_step = val;
        CFG_GAIN:   gain = val[15:0];
        CFG_FORMAT: fmt = fmt_t'(val[1:0]);
        CFG_OFFSET: offset_bin = val[0];
        default: ;
      endcase
    endfunction

    function longint fir_shift(ref longint line[6], input longint cur);
      longint acc;
      acc = 4 * line[0] + 16 * line[1] + 26 * line[2] + 36 * line[3]
          + 26 * line[4] + 16 * line[5] + 4 * cur;
      for (int k = 0; k < 5; k++) line[k] = line[k + 1];
      line[5] = cur;
      return acc >>> 7;
    endfunction

    function void note_request(logic [31:0] data);
      logic [22:0] ratio;
      logic [63:0] m;
      longint ni, nq, w, ci, cq, fi, fq, mixed, val, lim, b;
      int n;
      logic [11:0] idx;
      rf_exp_t e;
      ni = longint'($signed(data[15:0]));
      nq = longint'($signed(data[31:16]));
      ratio = (ratio_q16 > RATIO_MAX) ? RATIO_MAX : ratio_q16;
      lim = (fmt == FMT_BYTE || fmt == FMT_WORD8) ? 127 : 32767;
      n = 0;
      while (interp_phase < ratio && n < 64) begin
        m = ({41'd0, interp_phase} << 10) / {41'd0, ratio};
        w = wt_tab[m[9:0]];
        ci = (prev_i * (32768 - w) + ni * w) >>> 15;
        cq = (prev_q * (32768 - w) + nq * w) >>> 15;
        fi = fir_shift(line_i, ci);
        fq = fir_shift(line_q, cq);
        nco_phase = nco_phase + phase_step;
        idx = nco_phase[31:20];
        mixed = (fi * cos_tab[idx] - fq * sin_tab[idx]) >>> 15;
        val = (mixed * longint'(gain)) >>> 15;
        if (val > lim) val = lim;
        else if (val < -lim) val = -lim;
        if (fmt == FMT_BYTE) begin
          b = offset_bin ? val + 128 : val;
          e.rf = {8'd0, b[7:0]};
        end else begin
          e.rf = val[15:0];
        end
        e.last = 1'b0;
        rf_q.insert(rf_q.size(), e);
        n++;
        interp_phase = interp_phase + PHASE_ONE;
      end
      if (n > 0) rf_q[rf_q.size() - 1].last = 1'b1;
      interp_phase = interp_phase - ratio;
      prev_i = ni;
      prev_q = nq;
    endfunction

    function void check_result(logic [15:0] rf, logic last);
      rf_exp_t e;
      if (rf_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected rf sample %h last %b", rf, last);
        return;
      end
      e = rf_q.pop_front();
      if (rf !== e.rf || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("rf mismatch: expected %h last %b, got %h last %b", e.rf, e.last, rf, last);
      end
    endfunction

    function int pending();
      return rf_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // in_i[15:0], in_q[31:16]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // rf_sample[15:0]
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  upconv_scoreboard sb;
  logic [31:0] stim_q[$];
  bit quiet = 1'b0;
  int hold_req = 0;

  function automatic void add_stim(logic [31:0] d);
    stim_q.insert(stim_q.size(), d);
  endfunction

  always #5 clk = ~clk;

  integer_iq_upconverter_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // receiver with random stalls and an optional long hold-off
  initial begin
    int gap;
    forever begin
      if (hold_req > 0) begin
        @(negedge clk);
        out_tready = 1'b0;
        repeat (hold_req - 1) @(negedge clk);
        hold_req = 0;
      end
      gap = quiet ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
        @(negedge clk);
        out_tready = 1'b0;
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_requests();
    int gap;
    logic [31:0] d;
    while (stim_q.size() > 0) begin
      gap = quiet ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid = 1'b0;
      end
      d = stim_q.pop_front();
      @(negedge clk);
      in_tvalid = 1'b1;
      in_tdata = d;
      do @(posedge clk); while (!in_tready);
      sb.note_request(d);
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_extremes();
    add_stim({16'h7FFF, 16'h7FFF});
    add_stim({16'h8000, 16'h8000});
    add_stim({16'h8000, 16'h7FFF});
    add_stim({16'h7FFF, 16'h8000});
    add_stim(32'h0);
    add_stim({16'hFFFF, 16'h0001});
  endtask

  initial begin
    sb = new;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, about fifty samples per request
    add_stim({16'h7FFF, 16'h8000});
    add_stim({16'h8000, 16'h7FFF});
    add_stim(32'h0);
    send_requests();
    drain();

    // eight-bit offset bytes with full gain, heavy clipping
    write_reg(CFG_RATIO, 32'h28000);
    write_reg(CFG_STEP, $urandom());
    write_reg(CFG_GAIN, 32'hFFFF);
    write_reg(CFG_FORMAT, 32'(FMT_BYTE));
    write_reg(CFG_OFFSET, 32'd1);
    push_extremes();
    send_requests();
    drain();

    // eight-bit clip in a word, then spare format with offset ignored and zero gain
    write_reg(CFG_FORMAT, 32'(FMT_WORD8));
    write_reg(CFG_STEP, 32'hFFFF_FFFF);
    push_extremes();
    send_requests();
    drain();
    write_reg(CFG_FORMAT, 32'(FMT_SPARE));
    write_reg(CFG_GAIN, 32'd0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    add_stim({16'h7FFF, 16'h8000});
    send_requests();
    drain();

    // zero ratio gives nothing, minimum ratio, then ratio above range
    write_reg(CFG_GAIN, 32'd40000);
    write_reg(CFG_RATIO, 32'd0);
    add_stim({16'h1234, 16'h8000});
    add_stim({16'h7FFF, 16'h4321});
    send_requests();
    drain();
    write_reg(CFG_RATIO, 32'd1);
    add_stim({16'h0100, 16'h0200});
    send_requests();
    drain();
    write_reg(CFG_RATIO, 32'h7F_FFFF);
    write_reg(CFG_OFFSET, 32'd0);
    add_stim({16'h8000, 16'h7FFF});
    add_stim({16'h7FFF, 16'h8000});
    send_requests();
    drain();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      int cnt;
      if (ph == 5) begin
        write_reg(CFG_RATIO, 32'(RATIO_MAX));
        cnt = 4;
      end else begin
        write_reg(CFG_RATIO, $urandom_range(16384, 4 * 65536));
        cnt = 41;
      end
      write_reg(CFG_STEP, $urandom());
      case ($urandom_range(0, 3))
        0: write_reg(CFG_GAIN, 32'hFFFF);
        1: write_reg(CFG_GAIN, 32'(GAIN_RESET));
        default: write_reg(CFG_GAIN, $urandom_range(0, 65535));
      endcase
      write_reg(CFG_FORMAT, $urandom_range(0, 3));
      write_reg(CFG_OFFSET, $urandom_range(0, 1));
      quiet = (ph == 2);
      if (ph == 1) hold_req = 400;
      repeat (cnt) add_stim($urandom());
      send_requests();
      drain();
    end
    quiet = 1'b0;

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
